// ===== rtl/a85_pkg.sv =====
// Shared types, character codes and helper functions for the ASCII85 stream decoder.
`default_nettype none

package a85_pkg;

  // One input word: a source character and the end-of-source flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // One output word: a data byte or the end-of-stream status.
  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic [2:0] out_status;
    logic       out_last;
  } out_t;

  // Everything one input word causes: up to four data bytes and an optional status.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        has_status;
    logic [2:0]  status;
  } bundle_t;

  // Parser phases.
  localparam logic [2:0] PH_LT    = 3'd0;
  localparam logic [2:0] PH_TILDE = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_CLOSE = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_PRO   = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR = 3'd2;
  localparam logic [2:0] ST_Z_GROUP  = 3'd3;
  localparam logic [2:0] ST_TILDE    = 3'd4;
  localparam logic [2:0] ST_EARLY    = 3'd5;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Place value of the digit at position k of a group, most significant first.
  function automatic logic [31:0] weight85(input logic [2:0] k);
    logic [31:0] w;
    case (k)
      3'd0:    w = 32'd52200625;
      3'd1:    w = 32'd614125;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd85;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

  // Characters that the body skips.
  function automatic logic is_skip(input logic [7:0] c);
    return (c inside {8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20, CH_DEL});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/a85_core.sv =====
// Parser state and per-character decode into a bundle of results.
`default_nettype none

module a85_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire a85_pkg::in_t    in_data,
  output a85_pkg::bundle_t     bundle,
  output logic                 bundle_push
);

  logic [2:0]  phase, phase_next;
  logic [31:0] group_word, group_word_next;
  logic [2:0]  digit_count, digit_count_next;

  logic [7:0]  c;
  logic [6:0]  dv;
  logic [31:0] addend;
  logic [31:0] sum;
  logic [2:0]  close_k;

  assign c       = in_data.in_byte;
  assign dv      = 7'(c - a85_pkg::CH_BANG);
  assign close_k = digit_count - 3'd1;

  // One adder serves both the digit multiply-add and the rounding at the close.
  always_comb begin
    if (phase == a85_pkg::PH_CLOSE) begin
      addend = a85_pkg::weight85(close_k);
    end else begin
      addend = 32'(32'(dv) * a85_pkg::weight85(digit_count));
    end
  end

  assign sum = group_word + addend;

  always_comb begin
    phase_next       = phase;
    group_word_next  = group_word;
    digit_count_next = digit_count;
    bundle           = '0;

    case (phase)
      a85_pkg::PH_LT: begin
        if (c != a85_pkg::CH_LT) begin
          bundle.has_status = 1'b1;
          bundle.status     = a85_pkg::ST_NO_PRO;
          phase_next        = a85_pkg::PH_DONE;
        end else begin
          phase_next = a85_pkg::PH_TILDE;
        end
      end
      a85_pkg::PH_TILDE: begin
        if (c != a85_pkg::CH_TILDE) begin
          bundle.has_status = 1'b1;
          bundle.status     = a85_pkg::ST_NO_PRO;
          phase_next        = a85_pkg::PH_DONE;
        end else begin
          phase_next       = a85_pkg::PH_BODY;
          group_word_next  = '0;
          digit_count_next = '0;
        end
      end
      a85_pkg::PH_BODY: begin
        if (c inside {[a85_pkg::CH_BANG:a85_pkg::CH_U]}) begin
          if (digit_count == 3'd4) begin
            bundle.word      = sum;
            bundle.nbytes    = 3'd4;
            group_word_next  = '0;
            digit_count_next = '0;
          end else begin
            group_word_next  = sum;
            digit_count_next = digit_count + 3'd1;
          end
        end else if (c == a85_pkg::CH_Z) begin
          if (digit_count != 3'd0) begin
            bundle.has_status = 1'b1;
            bundle.status     = a85_pkg::ST_Z_GROUP;
            phase_next        = a85_pkg::PH_DONE;
          end else begin
            bundle.nbytes = 3'd4;
          end
        end else if (c == a85_pkg::CH_TILDE) begin
          phase_next = a85_pkg::PH_CLOSE;
        end else if (!a85_pkg::is_skip(c)) begin
          bundle.has_status = 1'b1;
          bundle.status     = a85_pkg::ST_BAD_CHAR;
          phase_next        = a85_pkg::PH_DONE;
        end
      end
      a85_pkg::PH_CLOSE: begin
        bundle.has_status = 1'b1;
        phase_next        = a85_pkg::PH_DONE;
        if (c == a85_pkg::CH_GT) begin
          bundle.status = a85_pkg::ST_OK;
          if (digit_count != 3'd0) begin
            bundle.word   = sum;
            bundle.nbytes = close_k;
          end
        end else begin
          bundle.status = a85_pkg::ST_TILDE;
        end
      end
      default: begin
        phase_next = a85_pkg::PH_DONE;
      end
    endcase

    // End of source: report an unfinished source and start over.
    if (in_data.in_last) begin
      if (phase_next != a85_pkg::PH_DONE) begin
        bundle.has_status = 1'b1;
        case (phase_next)
          a85_pkg::PH_BODY:  bundle.status = a85_pkg::ST_EARLY;
          a85_pkg::PH_CLOSE: bundle.status = a85_pkg::ST_TILDE;
          default:           bundle.status = a85_pkg::ST_NO_PRO;
        endcase
      end
      phase_next       = a85_pkg::PH_LT;
      group_word_next  = '0;
      digit_count_next = '0;
    end
  end

  assign bundle_push = accept && ((bundle.nbytes != 3'd0) || bundle.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= a85_pkg::PH_LT;
      group_word  <= '0;
      digit_count <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      group_word  <= group_word_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/a85_serial.sv =====
// Result register that hands out a bundle one output word per cycle while out_stall is low.
`default_nettype none

module a85_serial (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire a85_pkg::bundle_t  bundle,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output a85_pkg::out_t          out_data
);

  logic              bvalid;
  a85_pkg::bundle_t  b;
  logic [2:0]        idx;
  logic [2:0]        total;
  logic              take;
  logic              done;
  logic              is_status;

  assign total     = b.nbytes + {2'b00, b.has_status};
  assign take      = bvalid && !out_stall;
  assign done      = take && (idx == total - 3'd1);
  assign is_status = (idx == b.nbytes);

  // A new bundle may enter in the cycle the last word of the old one leaves.
  assign busy      = bvalid && !done;
  assign out_valid = bvalid;

  always_comb begin
    out_data          = '0;
    out_data.out_last = (idx == total - 3'd1);
    if (is_status) begin
      out_data.out_kind   = a85_pkg::KIND_STATUS;
      out_data.out_status = b.status;
    end else begin
      out_data.out_kind = a85_pkg::KIND_DATA;
      case (idx[1:0])
        2'd0:    out_data.out_byte = b.word[31:24];
        2'd1:    out_data.out_byte = b.word[23:16];
        2'd2:    out_data.out_byte = b.word[15:8];
        default: out_data.out_byte = b.word[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= '0;
    end else if (push) begin
      bvalid <= 1'b1;
      idx    <= '0;
    end else if (done) begin
      bvalid <= 1'b0;
      idx    <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      b <= bundle;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ascii85_stream_decoder_top.sv =====
// Top level of the ASCII85 stream decoder.
// The first result of an accepted word shows in the next cycle. Throughput: one word per
// cycle while out_stall is low and each word yields at most one result. A word with n
// results holds the result register, and with it the input, until its last result leaves.
// Reset (rst, synchronous, active high) empties the result register and re-arms the prologue.
`default_nettype none

module ascii85_stream_decoder_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire a85_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output a85_pkg::out_t      out_data
);

  logic              accept;
  logic              busy;
  logic              push;
  a85_pkg::bundle_t  bundle;

  // Input is held off only while the result register still has words to give
  // out after this cycle; the parser itself never holds the input off.
  // This holds for every word, including those that yield no result.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // Parser: prologue check, base-85 multiply-add and the end-of-source rules.
  // It turns each accepted character into a bundle of zero to five results.
  a85_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_data     (in_data),
    .bundle      (bundle),
    .bundle_push (push)
  );

  // Result register: data bytes leave most significant first, then the
  // status if there is one, and the final word of a bundle carries out_last.
  a85_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .bundle    (bundle),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/a85_check.sv =====
// Port-level checks for the ASCII85 stream decoder and their binding.
`default_nettype none

module a85_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire a85_pkg::out_t out_data
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // A status result closes its bundle and carries no byte.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind == a85_pkg::KIND_STATUS) |->
      out_data.out_last && (out_data.out_byte == 8'd0))
    else $error("malformed status result");

  // A data result carries a zero status field.
  a_data_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind == a85_pkg::KIND_DATA) |->
      (out_data.out_status == a85_pkg::ST_OK))
    else $error("data result with nonzero status");

  // The rest of a bundle follows without a gap.
  a_bundle_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.out_last |=> out_valid)
    else $error("bundle interrupted");

  // Reset empties the output side and frees the input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind ascii85_stream_decoder_top a85_check u_a85_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/a85_decode_check.sv =====
// Result checker for the ASCII85 stream decoder, with the character codes it shares with the bench.
`timescale 1ns / 1ps

package a85_tb_pkg;
  import a85_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam int N_SKIP = 8;
  localparam logic [7:0] SKIP_CODES [N_SKIP] =
    '{CH_NUL, CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP, CH_DEL};
endpackage

module a85_decode_check
  import a85_pkg::*, a85_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   mismatches,
  output int   outstanding,
  output int   n_checked
);

  // Decoder state as this side sees it.
  logic [2:0]  ph;
  logic [31:0] acc;
  logic [2:0]  ndig;
  int          made;

  // Results still owed by the block, oldest first.
  out_t decoded_q[$];

  function automatic logic [31:0] place_value(input logic [2:0] pos);
    logic [31:0] v;
    v = 32'd1;
    for (int i = pos; i < 4; i++) v = v * 32'd85;
    return v;
  endfunction

  function automatic logic ignorable(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_SKIP; i++) if (SKIP_CODES[i] == c) hit = 1'b1;
    return hit;
  endfunction

  task automatic put(input logic kind, input logic [7:0] b, input logic [2:0] st);
    out_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.out_status = st;
    r.out_last   = 1'b0;
    decoded_q.push_back(r);
    made++;
  endtask

  task automatic close_src(input logic [2:0] st);
    put(KIND_STATUS, 8'h00, st);
    ph = PH_DONE;
  endtask

  task automatic put_bytes(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) put(KIND_DATA, 8'(w >> (24 - 8 * i)), ST_OK);
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    made = 0;
    case (ph)
      PH_LT: begin
        if (c != CH_LT) close_src(ST_NO_PRO);
        else ph = PH_TILDE;
      end
      PH_TILDE: begin
        if (c != CH_TILDE) begin
          close_src(ST_NO_PRO);
        end else begin
          ph   = PH_BODY;
          acc  = '0;
          ndig = '0;
        end
      end
      PH_BODY: begin
        if (c >= CH_BANG && c <= CH_U) begin
          acc  = acc + 32'(c - CH_BANG) * place_value(ndig);
          ndig = ndig + 3'd1;
          if (ndig == 3'd5) begin
            put_bytes(acc, 4);
            acc  = '0;
            ndig = '0;
          end
        end else if (c == CH_Z) begin
          if (ndig != 3'd0) close_src(ST_Z_GROUP);
          else put_bytes(32'd0, 4);
        end else if (c == CH_TILDE) begin
          ph = PH_CLOSE;
        end else if (!ignorable(c)) begin
          close_src(ST_BAD_CHAR);
        end
      end
      PH_CLOSE: begin
        if (c == CH_GT) begin
          // A partial group is rounded up by one unit in the place of its last digit.
          if (ndig != 3'd0) begin
            acc = acc + place_value(ndig - 3'd1);
            put_bytes(acc, int'(ndig) - 1);
          end
          close_src(ST_OK);
        end else begin
          close_src(ST_TILDE);
        end
      end
      default: ph = PH_DONE;
    endcase

    if (last) begin
      if (ph == PH_LT || ph == PH_TILDE) close_src(ST_NO_PRO);
      else if (ph == PH_BODY) close_src(ST_EARLY);
      else if (ph == PH_CLOSE) close_src(ST_TILDE);
      ph   = PH_LT;
      acc  = '0;
      ndig = '0;
    end

    if (made > 0) decoded_q[decoded_q.size() - 1].out_last = 1'b1;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    n_checked++;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind=%0d byte=%02h status=%0d last=%0d",
                 $realtime, got.out_kind, got.out_byte, got.out_status, got.out_last);
    end else begin
      want = decoded_q.pop_front();
      if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
          got.out_status !== want.out_status || got.out_last !== want.out_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected kind=%0d byte=%02h status=%0d last=%0d, got %0d %02h %0d %0d",
                   $realtime, want.out_kind, want.out_byte, want.out_status, want.out_last,
                   got.out_kind, got.out_byte, got.out_status, got.out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph   = PH_LT;
      acc  = '0;
      ndig = '0;
      decoded_q.delete();
    end else begin
      // Check the result leaving first, then predict from the word entering.
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) decode_char(in_data.in_byte, in_data.in_last);
    end
    outstanding = decoded_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Stimulus and verdict for the ASCII85 stream decoder.
`timescale 1ns / 1ps

module tb;
  import a85_pkg::*;
  import a85_tb_pkg::*;

  // Number of random words to send after the directed sources.
  localparam int RANDOM_WORDS = 180;
  // The last stretch of the run has no idling on either side.
  localparam int QUIET_TAIL   = 40;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic quiet     = 1'b0;

  logic in_stall;
  logic out_valid;
  out_t out_data;

  int mismatches;
  int pending;
  int n_checked;

  // Words sent, words that the block ignores by design (trailing junk after a
  // finished source), and whole sources sent.
  int n_words   = 0;
  int n_ignored = 0;
  int n_sources = 0;
  int directed_words;

  // Text of the source under construction.
  logic [7:0] src_q[$];

  always #10 clk = ~clk;

  ascii85_stream_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The checker watches both channels and predicts every result on its own.
  a85_decode_check u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (pending),
    .n_checked   (n_checked)
  );

  // The result side stalls in bursts of random length. Between bursts there
  // are runs of free flow of random length, and none at all once the run goes
  // quiet.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hard stop in case the block hangs. The slowest correct run is well under
  // a tenth of this: a few hundred words, each with at most five results that
  // may each sit through a stall burst, plus sender gaps.
  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  // A base-85 digit, leaning toward the top of the range now and then so that
  // groups wrap past 2^32.
  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(CH_U - 4, CH_U));
    return 8'($urandom_range(CH_BANG, CH_U));
  endfunction

  task automatic maybe_skip();
    if ($urandom_range(0, 7) == 0) src_q.push_back(SKIP_CODES[$urandom_range(0, N_SKIP - 1)]);
  endtask

  // Sends one word and returns at the edge where the block takes it. A gap
  // drops valid for a burst of cycles first; valid is only raised after it,
  // so it never falls and rises within one step.
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_words++;
  endtask

  // The final byte of each source carries the last flag.
  task automatic send_source();
    for (int i = 0; i < src_q.size(); i++) send_word(src_q[i], i == src_q.size() - 1);
    src_q.delete();
    n_sources++;
  endtask

  // The sender holds off until the block has delivered everything owed. The
  // count is read at the falling edge, after the checker has seen the last word.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // A well-formed source: prologue, a few groups (some as z), an optional
  // partial tail, the closing marker, with whitespace sprinkled in.
  task automatic build_clean();
    int ngrp;
    int tail;
    push_text("<~");
    ngrp = $urandom_range(0, 3);
    repeat (ngrp) begin
      maybe_skip();
      if ($urandom_range(0, 4) == 0) begin
        src_q.push_back(CH_Z);
      end else begin
        repeat (5) begin
          maybe_skip();
          src_q.push_back(rand_digit());
        end
      end
    end
    tail = $urandom_range(0, 4);
    repeat (tail) src_q.push_back(rand_digit());
    maybe_skip();
    src_q.push_back(CH_TILDE);
    src_q.push_back(CH_GT);
  endtask

  // Most sources are well formed. The rest are cut short, have one byte
  // overwritten with anything at all, or are plain noise.
  task automatic build_random_source();
    int pick;
    int cut;
    int idx;
    int n;
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      build_clean();
      // Bytes after a finished source are ignored up to the last flag.
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) src_q.push_back(8'($urandom_range(0, 255)));
        n_ignored += n;
      end
    end else if (pick == 7) begin
      build_clean();
      cut = $urandom_range(1, src_q.size() - 1);
      while (src_q.size() > cut) void'(src_q.pop_back());
    end else if (pick == 8) begin
      build_clean();
      idx = $urandom_range(0, src_q.size() - 1);
      src_q[idx] = 8'($urandom_range(0, 255));
    end else begin
      if ($urandom_range(0, 1) == 0) push_text("<~");
      n = $urandom_range(1, 6);
      repeat (n) src_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int waited;
    int total_err;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed sources. The first one decodes a z group, skips a NUL, wraps a
    // group of five top digits past 2^32 and ends with a one-digit tail, which
    // adds no bytes.
    push_text("<~z");
    src_q.push_back(CH_NUL);
    push_text("uuuuuu~>");
    send_source();
    // Wrong opening byte (0xFF); the rest of the source is ignored.
    src_q.push_back(8'hFF);
    push_text("<");
    send_source();
    // A z inside a group, on the last byte.
    push_text("<~!z");
    send_source();
    // The source ends right after a tilde.
    push_text("<~~");
    send_source();
    // The source ends with a group of one digit.
    push_text("<~!");
    send_source();
    // A byte from the upper half is a bad character.
    push_text("<~");
    src_q.push_back(8'h80);
    send_source();
    directed_words = n_words;

    // Let everything drain before the random part starts.
    drain();

    // Random sources until enough meaningful words have gone in. One more
    // full drain sits in the middle, and the tail runs without any idling.
    while (n_words - n_ignored < directed_words + RANDOM_WORDS) begin
      if (!quiet && n_words - n_ignored >= directed_words + RANDOM_WORDS - QUIET_TAIL)
        quiet <= 1'b1;
      build_random_source();
      send_source();
      if (n_sources == 15) drain();
    end
    in_valid <= 1'b0;

    // Wait for all owed results, bounded, then a few cycles for strays.
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    total_err = mismatches + pending;
    $display("Sent %0d sources in %0d words and checked %0d results,", n_sources, n_words,
             n_checked);
    $display("covering every status code, z groups, wrapping groups and idling on both sides.");
    if (total_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
